[rtl/bgd_pkg.sv]
`default_nettype none
package bgd_pkg;

   // graph size limits
   localparam int VERT_MAX = 256;
   localparam int EDGE_MAX = 1024;

   localparam int VID_W   = $clog2(VERT_MAX);
   localparam int VCNT_W  = $clog2(VERT_MAX + 1);
   localparam int EADDR_W = $clog2(EDGE_MAX);
   localparam int ECNT_W  = $clog2(EDGE_MAX + 1);
   localparam int DIST_W  = VID_W + 1;
   localparam int EDGE_W  = 2 * VID_W;

   // field widths of the channels
   localparam int KIND_W  = 2;
   localparam int SRC_W   = 8;
   localparam int DIAM_W  = 8;
   localparam int CFG_W   = 9;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_VERTEX_COUNT = 1'b0;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

   // hop distance of a vertex not yet reached
   localparam logic [DIST_W-1:0] DIST_NONE = '1;

   // controller to datapath commands
   typedef struct packed {
      logic take_req;
      logic start;
      logic vidx_clr;
      logic vidx_inc;
      logic mark_clr_wr;
      logic dist_clr_wr;
      logic root_inc;
      logic phase_next;
      logic root_load;
      logic seed;
      logic level_next;
      logic edge_step;
      logic scan_addr;
      logic scan_chk;
      logic search_end;
      logic result_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic              req_valid;
      logic [KIND_W-1:0] req_kind;
      logic              req_approx;
      logic              vidx_end;
      logic              root_end;
      logic              skip_root;
      logic              edge_end;
      logic              added;
      logic              final_phase;
      logic              rsp_free;
   } stat_type;

endpackage
`default_nettype wire

[rtl/bgd_if.sv]
`default_nettype none
interface bgd_req_if import bgd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SRC_W-1:0]  edge_src;
   logic [SRC_W-1:0]  edge_dst;
   logic              approximate;

   modport source (output valid, kind, edge_src, edge_dst, approximate, input ready);
   modport sink (input valid, kind, edge_src, edge_dst, approximate, output ready);
endinterface

interface bgd_rsp_if import bgd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DIAM_W-1:0] diameter_value;
   logic              edge_overflow;
   logic              bad_endpoint;

   modport source (output valid, diameter_value, edge_overflow, bad_endpoint, input ready);
   modport sink (input valid, diameter_value, edge_overflow, bad_endpoint, output ready);
endinterface
`default_nettype wire

[rtl/bfs_graph_diameter_unit.sv]
// channel    dir   handshake      payload
// req_ch     in    valid/ready    kind, edge_src, edge_dst, approximate
// rsp_ch     out   valid/ready    diameter_value, edge_overflow, bad_endpoint
// psel...    in    apb, pready=1  vertex_count at byte addresses 0 to 3
//
// load and clear requests are taken in the idle state; a compute request holds the
// input until its result is registered. the time of one search from a root is set
// mostly by the edge sweep, which reads the edge memory and both distance ports per
// edge. exact mode runs n searches (n = vertex count); approximate mode instead
// clears the marks, skips marked roots, runs one search per component and one per
// candidate.
// reset is synchronous; a pending result stalls only the next compute.
`default_nettype none
module bfs_graph_diameter_unit import bgd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   bgd_req_if.sink                req_ch,
   bgd_rsp_if.source              rsp_ch,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0]      prdata,
   output logic                   pready
);

   cmd_type          cmd;
   stat_type         stat;
   logic             cfg_we;
   logic [CFG_W-1:0] vcount;

   // register access
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[CSR_AW-1] == CSR_VERTEX_COUNT);
   assign prdata = (paddr[CSR_AW-1] == CSR_VERTEX_COUNT) ? CSR_DW'(vcount) : '0;

   bgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_ch.ready)
   );

   bgd_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_valid    (req_ch.valid),
      .req_kind     (req_ch.kind),
      .req_src      (req_ch.edge_src),
      .req_dst      (req_ch.edge_dst),
      .req_approx   (req_ch.approximate),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_diameter (rsp_ch.diameter_value),
      .rsp_overflow (rsp_ch.edge_overflow),
      .rsp_bad      (rsp_ch.bad_endpoint),
      .cfg_we       (cfg_we),
      .cfg_wdata    (pwdata[CFG_W-1:0]),
      .vcount       (vcount)
   );

endmodule
`default_nettype wire

[rtl/bgd_ram.sv]
`default_nettype none
module bgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/bgd_datapath.sv]
`default_nettype none
module bgd_datapath import bgd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output stat_type               stat,
   input  wire logic              req_valid,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic [SRC_W-1:0]  req_src,
   input  wire logic [SRC_W-1:0]  req_dst,
   input  wire logic              req_approx,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [DIAM_W-1:0]      rsp_diameter,
   output logic                   rsp_overflow,
   output logic                   rsp_bad,
   input  wire logic              cfg_we,
   input  wire logic [CFG_W-1:0]  cfg_wdata,
   output logic [CFG_W-1:0]       vcount
);

   logic [CFG_W-1:0]  vcount_ff, vcount_in;
   logic [ECNT_W-1:0] etotal_ff, etotal_in;
   logic [1:0]        flags_ff, flags_in;
   logic              approx_ff, approx_in;
   logic              final_ff, final_in;
   logic [VCNT_W-1:0] root_ff, root_in;
   logic [VID_W-1:0]  sroot_ff, sroot_in;
   logic [VCNT_W-1:0] vidx_ff, vidx_in;
   logic [ECNT_W-1:0] eidx_ff, eidx_in;
   logic [DIST_W-1:0] level_ff, level_in;
   logic              added_ff, added_in;
   logic              far_ff, far_in;
   logic [VCNT_W-1:0] ncand_ff, ncand_in;
   logic [DIAM_W-1:0] best_ff, best_in;
   logic              rspv_ff, rspv_in;
   logic [DIAM_W-1:0] rspd_ff, rspd_in;
   logic [1:0]        rspf_ff, rspf_in;

   logic [VCNT_W-1:0] n_live;
   logic [VCNT_W-1:0] root_lim;
   logic              load_bad, load_ok;
   logic [EDGE_W-1:0] edge_rd;
   logic [VID_W-1:0]  edge_a, edge_b;
   logic              edge_in_range;
   logic [DIST_W-1:0] dist_a, dist_b;
   logic              step_a, step_b;
   logic              dist_we;
   logic [VID_W-1:0]  dist_waddr, dist_raddr;
   logic [DIST_W-1:0] dist_wdata;
   logic              mark_we, mark_wdata, mark_rd;
   logic              cand_we;
   logic [VID_W-1:0]  cand_rd;
   logic              at_far;

   // live vertex count, capped at the table size
   assign n_live = (vcount_ff > CFG_W'(VERT_MAX)) ? VCNT_W'(VERT_MAX) : VCNT_W'(vcount_ff);
   assign root_lim = (approx_ff && final_ff) ? ncand_ff : n_live;

   // edge load checks
   assign load_bad = ({1'b0, req_src} >= n_live) || ({1'b0, req_dst} >= n_live);
   assign load_ok  = cmd.take_req && (req_kind == KIND_LOAD) && !load_bad &&
                     (etotal_ff != ECNT_W'(EDGE_MAX));

   // current edge and its endpoint distances
   assign edge_a = edge_rd[EDGE_W-1:VID_W];
   assign edge_b = edge_rd[VID_W-1:0];
   assign edge_in_range = ({1'b0, edge_a} < n_live) && ({1'b0, edge_b} < n_live);
   assign step_b = edge_in_range && (dist_a == level_ff) && (dist_b == DIST_NONE);
   assign step_a = edge_in_range && (dist_b == level_ff) && (dist_a == DIST_NONE);

   // distance store write select
   always_comb begin
      dist_we    = 1'b0;
      dist_waddr = vidx_ff[VID_W-1:0];
      dist_wdata = DIST_NONE;
      if (cmd.dist_clr_wr) begin
         dist_we = 1'b1;
      end else if (cmd.seed) begin
         dist_we    = 1'b1;
         dist_waddr = sroot_ff;
         dist_wdata = '0;
      end else if (cmd.edge_step && step_b) begin
         dist_we    = 1'b1;
         dist_waddr = edge_b;
         dist_wdata = level_ff + DIST_W'(1);
      end else if (cmd.edge_step && step_a) begin
         dist_we    = 1'b1;
         dist_waddr = edge_a;
         dist_wdata = level_ff + DIST_W'(1);
      end
   end
   assign dist_raddr = cmd.scan_addr ? vidx_ff[VID_W-1:0] : edge_a;

   // scan: first vertex at the last level is the farthest one
   assign at_far     = (dist_a == level_ff) && (level_ff != '0) && !far_ff;
   assign mark_we    = cmd.mark_clr_wr || (cmd.scan_chk && !final_ff && (dist_a != DIST_NONE));
   assign mark_wdata = !cmd.mark_clr_wr;
   assign cand_we    = cmd.scan_chk && !final_ff && at_far;

   bgd_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_MAX)) u_edge_ram (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (etotal_ff[EADDR_W-1:0]),
      .wr_data ({req_src, req_dst}),
      .rd_addr (eidx_ff[EADDR_W-1:0]),
      .rd_data (edge_rd)
   );

   bgd_ram #(.WIDTH(DIST_W), .DEPTH(VERT_MAX)) u_dist_ram_a (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (dist_raddr),
      .rd_data (dist_a)
   );

   bgd_ram #(.WIDTH(DIST_W), .DEPTH(VERT_MAX)) u_dist_ram_b (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (edge_b),
      .rd_data (dist_b)
   );

   bgd_ram #(.WIDTH(1), .DEPTH(VERT_MAX)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (vidx_ff[VID_W-1:0]),
      .wr_data (mark_wdata),
      .rd_addr (root_ff[VID_W-1:0]),
      .rd_data (mark_rd)
   );

   bgd_ram #(.WIDTH(VID_W), .DEPTH(VERT_MAX)) u_cand_ram (
      .clock   (clock),
      .wr_en   (cand_we),
      .wr_addr (ncand_ff[VID_W-1:0]),
      .wr_data (vidx_ff[VID_W-1:0]),
      .rd_addr (root_ff[VID_W-1:0]),
      .rd_data (cand_rd)
   );

   // next state of the datapath registers
   always_comb begin
      vcount_in = vcount_ff;
      etotal_in = etotal_ff;
      flags_in  = flags_ff;
      approx_in = approx_ff;
      final_in  = final_ff;
      root_in   = root_ff;
      sroot_in  = sroot_ff;
      vidx_in   = vidx_ff;
      eidx_in   = eidx_ff;
      level_in  = level_ff;
      added_in  = added_ff;
      far_in    = far_ff;
      ncand_in  = ncand_ff;
      best_in   = best_ff;
      rspv_in   = rspv_ff;
      rspd_in   = rspd_ff;
      rspf_in   = rspf_ff;

      if (cfg_we) begin
         vcount_in = cfg_wdata;
      end

      // load and clear requests
      if (cmd.take_req && (req_kind == KIND_LOAD)) begin
         if (load_bad) begin
            flags_in[1] = 1'b1;
         end else if (etotal_ff == ECNT_W'(EDGE_MAX)) begin
            flags_in[0] = 1'b1;
         end else begin
            etotal_in = etotal_ff + ECNT_W'(1);
         end
      end
      if (cmd.take_req && (req_kind == KIND_CLEAR)) begin
         etotal_in = '0;
         flags_in  = '0;
      end

      // compute start
      if (cmd.start) begin
         approx_in = req_approx;
         final_in  = !req_approx;
         root_in   = '0;
         vidx_in   = '0;
         ncand_in  = '0;
         best_in   = '0;
      end

      // root selection
      if (cmd.phase_next) begin
         final_in = 1'b1;
         root_in  = '0;
      end
      if (cmd.root_inc) begin
         root_in = root_ff + VCNT_W'(1);
      end
      if (cmd.root_load) begin
         sroot_in = (approx_ff && final_ff) ? cand_rd : root_ff[VID_W-1:0];
      end

      // vertex sweep counter
      if (cmd.vidx_clr) begin
         vidx_in = '0;
      end
      if (cmd.vidx_inc) begin
         vidx_in = vidx_ff + VCNT_W'(1);
      end

      // level by level edge sweeps
      if (cmd.seed) begin
         level_in = '0;
         added_in = 1'b0;
         far_in   = 1'b0;
         eidx_in  = '0;
      end
      if (cmd.level_next) begin
         level_in = level_ff + DIST_W'(1);
         added_in = 1'b0;
         eidx_in  = '0;
      end
      if (cmd.edge_step) begin
         eidx_in = eidx_ff + ECNT_W'(1);
         if (step_a || step_b) begin
            added_in = 1'b1;
         end
      end

      if (cand_we) begin
         far_in = 1'b1;
      end

      // search result
      if (cmd.search_end) begin
         if (final_ff) begin
            if (level_ff[DIAM_W-1:0] > best_ff) begin
               best_in = level_ff[DIAM_W-1:0];
            end
         end else if (far_ff) begin
            ncand_in = ncand_ff + VCNT_W'(1);
         end
      end

      // response register
      if (rspv_ff && rsp_ready) begin
         rspv_in = 1'b0;
      end
      if (cmd.result_load) begin
         rspv_in = 1'b1;
         rspd_in = best_ff;
         rspf_in = flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= CFG_W'(1);
         etotal_ff <= '0;
         flags_ff  <= '0;
         rspv_ff   <= 1'b0;
      end else begin
         vcount_ff <= vcount_in;
         etotal_ff <= etotal_in;
         flags_ff  <= flags_in;
         rspv_ff   <= rspv_in;
      end
      approx_ff <= approx_in;
      final_ff  <= final_in;
      root_ff   <= root_in;
      sroot_ff  <= sroot_in;
      vidx_ff   <= vidx_in;
      eidx_ff   <= eidx_in;
      level_ff  <= level_in;
      added_ff  <= added_in;
      far_ff    <= far_in;
      ncand_ff  <= ncand_in;
      best_ff   <= best_in;
      rspd_ff   <= rspd_in;
      rspf_ff   <= rspf_in;
   end

   // status to the controller
   always_comb begin
      stat.req_valid   = req_valid;
      stat.req_kind    = req_kind;
      stat.req_approx  = req_approx;
      stat.vidx_end    = (vidx_ff == n_live);
      stat.root_end    = (root_ff == root_lim);
      stat.skip_root   = !final_ff && mark_rd;
      stat.edge_end    = (eidx_ff == etotal_ff);
      stat.added       = added_ff;
      stat.final_phase = final_ff;
      stat.rsp_free    = !rspv_ff || rsp_ready;
   end

   assign rsp_valid    = rspv_ff;
   assign rsp_diameter = rspd_ff;
   assign rsp_overflow = rspf_ff[0];
   assign rsp_bad      = rspf_ff[1];
   assign vcount       = vcount_ff;

endmodule
`default_nettype wire

[rtl/bgd_ctrl.sv]
`default_nettype none
module bgd_ctrl import bgd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire stat_type stat,
   output cmd_type       cmd,
   output logic          req_ready
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_MCLR  = 13'b0000000000010,
      ST_RSEL  = 13'b0000000000100,
      ST_RWAIT = 13'b0000000001000,
      ST_DCLR  = 13'b0000000010000,
      ST_SEED  = 13'b0000000100000,
      ST_EREAD = 13'b0000001000000,
      ST_EWAIT = 13'b0000010000000,
      ST_DWAIT = 13'b0000100000000,
      ST_SREAD = 13'b0001000000000,
      ST_SCHK  = 13'b0010000000000,
      ST_SDONE = 13'b0100000000000,
      ST_FIN   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // sequencing of searches, sweeps and scans
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (stat.req_valid) begin
               cmd.take_req = 1'b1;
               if (stat.req_kind == KIND_COMPUTE) begin
                  cmd.start = 1'b1;
                  state_in  = stat.req_approx ? ST_MCLR : ST_RSEL;
               end
            end
         end
         ST_MCLR: begin
            if (stat.vidx_end) begin
               state_in = ST_RSEL;
            end else begin
               cmd.mark_clr_wr = 1'b1;
               cmd.vidx_inc    = 1'b1;
            end
         end
         ST_RSEL: begin
            if (stat.root_end) begin
               if (stat.final_phase) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.phase_next = 1'b1;
               end
            end else begin
               state_in = ST_RWAIT;
            end
         end
         ST_RWAIT: begin
            if (stat.skip_root) begin
               cmd.root_inc = 1'b1;
               state_in     = ST_RSEL;
            end else begin
               cmd.root_load = 1'b1;
               cmd.vidx_clr  = 1'b1;
               state_in      = ST_DCLR;
            end
         end
         ST_DCLR: begin
            if (stat.vidx_end) begin
               state_in = ST_SEED;
            end else begin
               cmd.dist_clr_wr = 1'b1;
               cmd.vidx_inc    = 1'b1;
            end
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            state_in = ST_EREAD;
         end
         ST_EREAD: begin
            if (stat.edge_end) begin
               if (stat.added) begin
                  cmd.level_next = 1'b1;
               end else begin
                  cmd.vidx_clr = 1'b1;
                  state_in     = ST_SREAD;
               end
            end else begin
               state_in = ST_EWAIT;
            end
         end
         ST_EWAIT: begin
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            cmd.edge_step = 1'b1;
            state_in      = ST_EREAD;
         end
         ST_SREAD: begin
            cmd.scan_addr = 1'b1;
            state_in      = stat.vidx_end ? ST_SDONE : ST_SCHK;
         end
         ST_SCHK: begin
            cmd.scan_addr = 1'b1;
            cmd.scan_chk  = 1'b1;
            cmd.vidx_inc  = 1'b1;
            state_in      = ST_SREAD;
         end
         ST_SDONE: begin
            cmd.search_end = 1'b1;
            cmd.root_inc   = 1'b1;
            state_in       = ST_RSEL;
         end
         ST_FIN: begin
            if (stat.rsp_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/bgd_checker.sv]
`default_nettype none
module bgd_checker import bgd_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [KIND_W-1:0] req_kind,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DIAM_W-1:0] rsp_diameter,
   input wire logic              rsp_overflow,
   input wire logic              rsp_bad
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_diameter) && $stable(rsp_overflow) &&
      $stable(rsp_bad))
      else $error("result payload changed while stalled");

   // reset leaves no result pending
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an accepted compute request closes the input
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_COMPUTE) |=> !req_ready)
      else $error("input open right after compute request");

   // a new result follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a compute in progress");

endmodule

bind bfs_graph_diameter_unit bgd_checker u_bgd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_kind     (req_ch.kind),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_diameter (rsp_ch.diameter_value),
   .rsp_overflow (rsp_ch.edge_overflow),
   .rsp_bad      (rsp_ch.bad_endpoint)
);
`default_nettype wire
